// ===== sv/ftis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftis_pkg
// Shared types, codes and helpers for the frame time to index search block.
// ----------------------------------------------------------------------------
package ftis_pkg;

  // field widths
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned FRAME_W = 10;
  localparam int unsigned START_W = 31;
  localparam int unsigned TIME_W  = 41;

  // default table depth
  localparam int unsigned MAX_FRAMES_DEF = 1024;

  // configuration register reset values
  localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = COUNT_W'(1);
  localparam logic [TIME_W-1:0]  CLIP_DUR_RST    = '0;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_TIME_RANGE = 2'd1,
    STAT_LOAD_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    REG_FRAME_COUNT   = 1'b0,
    REG_CLIP_DURATION = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_MID,
    S_RD_NEXT,
    S_CMP,
    S_RESP
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [FRAME_W-1:0] entry_index;
    logic [START_W-1:0] start_time_ms;
    logic [TIME_W-1:0]  query_time_us;
  } in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] found_frame;
    status_e            status;
  } out_t;

  typedef struct packed {
    logic [COUNT_W-1:0] frame_count;
    logic [TIME_W-1:0]  clip_duration_us;
  } cfg_t;

  // milliseconds to microseconds: x * 1000 = x*1024 - x*16 - x*8
  function automatic logic [TIME_W-1:0] ms_to_us(input logic [START_W-1:0] ms);
    logic [TIME_W-1:0] x;
    x = TIME_W'(ms);
    return (x << 10) - (x << 4) - (x << 3);
  endfunction

endpackage
`default_nettype wire

// ===== sv/ftis_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftis_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ftis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/ftis_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftis_search
// Start time table and binary search sequencer: loads entries, runs probes.
// ----------------------------------------------------------------------------
module ftis_search #(
  parameter int unsigned MAX_FRAMES = ftis_pkg::MAX_FRAMES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ftis_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ftis_pkg::in_t in_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output ftis_pkg::out_t     res_o
);
  import ftis_pkg::*;

  localparam int unsigned AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  state_e             state_q, state_d;
  logic [AW-1:0]      lo_q, lo_d;
  logic [AW-1:0]      hi_q, hi_d;
  logic [AW-1:0]      mid_q, mid_d;
  logic [AW-1:0]      last_q, last_d;
  logic [TIME_W-1:0]  t_q, t_d;
  logic [TIME_W-1:0]  s_us_q, s_us_d;
  out_t               res_q, res_d;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [START_W-1:0] ram_rdata;
  logic [AW-1:0]      mid_calc;
  logic [TIME_W-1:0]  next_us;
  logic               past_end;
  logic               load_ok;

  ftis_ram #(
    .WIDTH (START_W),
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_i.start_time_ms),
    .rdata_o (ram_rdata)
  );

  // probe midpoint, lo <= hi holds while searching
  assign mid_calc = lo_q + ((hi_q - lo_q) >> 1);

  // end of the probed frame: next start or clip duration for the last frame
  assign next_us  = ms_to_us(ram_rdata);
  assign past_end = (mid_q == last_q) ? (t_q > cfg_i.clip_duration_us)
                                      : (t_q >= next_us);

  assign load_ok = (32'(in_i.entry_index) < 32'(MAX_FRAMES));

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    last_q <= last_d;
    t_q    <= t_d;
    s_us_q <= s_us_d;
    res_q  <= res_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    last_d      = last_q;
    t_d         = t_q;
    s_us_d      = s_us_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_addr    = mid_calc;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        ram_addr   = AW'(in_i.entry_index);
        if (in_valid_i) begin
          res_d.found_frame = '0;
          res_d.status      = STAT_OK;
          if (in_i.cmd == CMD_LOAD) begin
            ram_we = load_ok;
            if (!load_ok) begin
              res_d.status = STAT_LOAD_RANGE;
            end
            state_d = S_RESP;
          end else begin
            t_d  = in_i.query_time_us;
            lo_d = '0;
            if (32'(cfg_i.frame_count) > 32'(MAX_FRAMES)) begin
              last_d = AW'(MAX_FRAMES - 1);
            end else begin
              last_d = AW'(cfg_i.frame_count - COUNT_W'(1));
            end
            hi_d = last_d;
            if ((cfg_i.frame_count == '0) ||
                (in_i.query_time_us > cfg_i.clip_duration_us)) begin
              res_d.status = STAT_TIME_RANGE;
              state_d      = S_RESP;
            end else begin
              state_d = S_RD_MID;
            end
          end
        end
      end
      S_RD_MID: begin
        ram_addr = mid_calc;
        mid_d    = mid_calc;
        state_d  = S_RD_NEXT;
      end
      S_RD_NEXT: begin
        // start of the probed frame is back, fetch the next start
        s_us_d   = ms_to_us(ram_rdata);
        ram_addr = mid_q + AW'(1);
        state_d  = S_CMP;
      end
      S_CMP: begin
        ram_addr = mid_q;
        if (t_q < s_us_q) begin
          if (mid_q == lo_q) begin
            res_d.status = STAT_TIME_RANGE;
            state_d      = S_RESP;
          end else begin
            hi_d    = mid_q - AW'(1);
            state_d = S_RD_MID;
          end
        end else if (past_end) begin
          if (mid_q == hi_q) begin
            res_d.status = STAT_TIME_RANGE;
            state_d      = S_RESP;
          end else begin
            lo_d    = mid_q + AW'(1);
            state_d = S_RD_MID;
          end
        end else begin
          res_d.found_frame = FRAME_W'(mid_q);
          state_d           = S_RESP;
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== sv/frame_time_to_index_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_time_to_index_search
// Frame start time table with a binary search from a time to a frame index.
// ----------------------------------------------------------------------------
// A load transaction writes one start time (ms) into the table and then goes
// to its result state. A lookup transaction runs a binary search over the
// first frame_count entries; each probe steps through S_RD_MID, S_RD_NEXT
// and S_CMP because the single table port returns the frame start and then
// the next frame start, and a lookup takes up to ceil(log2(n+1)) probes.
// Times before the first frame or past the clip duration report a time
// range status. One transaction is in work at a time; a finished result
// waits in the output register while the next one starts.
module frame_time_to_index_search #(
  parameter int unsigned MAX_FRAMES = ftis_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_index_i,
  input  wire logic [ftis_pkg::TIME_W-1:0] cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ftis_pkg::in_t               in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output ftis_pkg::out_t                   out_o
);
  import ftis_pkg::*;

  logic [COUNT_W-1:0] frame_count_q;
  logic [TIME_W-1:0]  clip_dur_q;
  cfg_t               cfg;
  logic               res_valid;
  logic               res_ready;
  out_t               res;
  logic               out_valid_q;
  out_t               out_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RST;
      clip_dur_q    <= CLIP_DUR_RST;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_FRAME_COUNT:   frame_count_q <= cfg_data_i[COUNT_W-1:0];
        REG_CLIP_DURATION: clip_dur_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg.frame_count      = frame_count_q;
  assign cfg.clip_duration_us = clip_dur_q;

  ftis_search #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  // a failed search never reports a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != STAT_OK) |-> (out_o.found_frame == '0))
    else $error("nonzero frame with error status");

  // a found frame lies inside the loaded count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == STAT_OK) |->
      (COUNT_W'(out_o.found_frame) < frame_count_q))
    else $error("found frame beyond frame count");

  // lookup with no frames answers at once with a time range status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_i.cmd == CMD_LOOKUP) && (frame_count_q == '0)
      |=> res_valid && (res.status == STAT_TIME_RANGE))
    else $error("empty table lookup not rejected");

  // a load answers in the next cycle and never with a time status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_i.cmd == CMD_LOAD)
      |=> res_valid && (res.status != STAT_TIME_RANGE))
    else $error("bad load response");
`endif

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frame time to index search block.
// ----------------------------------------------------------------------------
// Start time loads and time lookups go in through a queue-fed driver. Every
// accepted transaction is run through a local copy of the start time table
// and the binary search, and the predicted frame and status are queued. The
// monitor checks each returned result against the oldest prediction. A short
// directed sequence comes first, with a zero frame count, equal
// and unordered start times and times on both sides of each interval edge.
// The whole table is then filled once, and random phases follow, each with
// its own frame count, clip duration and mix of boundary and random times.
// ----------------------------------------------------------------------------
module testbench;
  import ftis_pkg::*;

  localparam int unsigned DEPTH         = MAX_FRAMES_DEF;
  localparam int unsigned ITEMS_TOTAL   = 1050;
  localparam int unsigned RANDOM_ITEMS  = 64;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [START_W-1:0] START_MAX = '1;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic [TIME_W-1:0]  cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_t                in_i        = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_t               out_o;

  // transactions waiting for the driver and predicted results in order
  in_t  pending_requests[$];
  out_t frame_answers_q[$];

  // predictor state, updated on accepted transactions and register writes
  logic [START_W-1:0] stored_start_ms [DEPTH];
  logic [COUNT_W-1:0] frame_count_cfg = FRAME_COUNT_RST;
  logic [TIME_W-1:0]  clip_dur_cfg    = CLIP_DUR_RST;

  // table contents as planned by the stimulus, ahead of acceptance
  logic [START_W-1:0] plan_start_ms [DEPTH];

  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 87;
  int unsigned hold_kicks    = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  int unsigned n_queued   = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_loads    = 0;
  int unsigned n_lookups  = 0;
  int unsigned n_misses   = 0;
  int unsigned n_settings = 0;

  frame_time_to_index_search #(
    .MAX_FRAMES(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("timeout with %0d of %0d results checked", n_checked, n_queued);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TIME_W-1:0] rand41();
    logic [63:0] r;
    r = rand64();
    return r[TIME_W-1:0];
  endfunction

  // binary search over the predictor table, -1 when no frame holds the time
  function automatic longint locate_frame(logic [TIME_W-1:0] t);
    longint n, lo, hi, mid, s, e, tt, dur;
    n   = longint'(frame_count_cfg);
    tt  = longint'(t);
    dur = longint'(clip_dur_cfg);
    lo  = 0;
    if (n > longint'(DEPTH)) n = longint'(DEPTH);
    if (n <= 0) return -1;
    if (tt > dur) return -1;
    hi = n - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      s   = longint'(stored_start_ms[mid]) * 1000;
      if (mid < n - 1) e = longint'(stored_start_ms[mid + 1]) * 1000 - 1;
      else e = dur;
      if (tt < s) hi = mid - 1;
      else if (tt > e) lo = mid + 1;
      else return mid;
    end
    return -1;
  endfunction

  // apply one accepted transaction and queue the result it must produce
  function automatic void resolve_request(in_t it);
    out_t   ans;
    longint hit;
    ans.found_frame = '0;
    ans.status      = STAT_OK;
    if (it.cmd == CMD_LOAD) begin
      n_loads++;
      if (int'(it.entry_index) < int'(DEPTH)) stored_start_ms[it.entry_index] = it.start_time_ms;
      else ans.status = STAT_LOAD_RANGE;
    end else begin
      n_lookups++;
      hit = locate_frame(it.query_time_us);
      if (hit < 0) begin
        ans.status = STAT_TIME_RANGE;
        n_misses++;
      end else begin
        ans.found_frame = hit[FRAME_W-1:0];
      end
    end
    frame_answers_q.push_back(ans);
  endfunction

  function automatic void compare_answer(out_t got);
    out_t want;
    n_checked++;
    if (frame_answers_q.size() == 0) begin
      n_errors++;
      if (n_errors <= REPORT_LIMIT)
        $display("unexpected result: frame %0d status %0d", got.found_frame, got.status);
    end else begin
      want = frame_answers_q.pop_front();
      if (got.found_frame !== want.found_frame || got.status !== want.status) begin
        n_errors++;
        if (n_errors <= REPORT_LIMIT)
          $display("mismatch on result %0d: expected frame %0d status %0d, got frame %0d status %0d",
                   n_checked, want.found_frame, want.status, got.found_frame, got.status);
      end
    end
  endfunction

  // idle mix by the number of accepted transactions
  always @(posedge clk_i) begin
    if (n_loads + n_lookups < ITEMS_TOTAL / 3) begin
      send_idle_pct <= 28;
      recv_idle_pct <= 87;
    end else if (n_loads + n_lookups < 2 * ITEMS_TOTAL / 3) begin
      send_idle_pct <= 87;
      recv_idle_pct <= 28;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  end

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) resolve_request(in_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_i       <= pending_requests.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) compare_answer(out_o);
      out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off, started on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_kicks != hold_seen) begin
      hold_seen <= hold_kicks;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic void queue_load(logic [FRAME_W-1:0] idx, logic [START_W-1:0] ms);
    in_t it;
    it.cmd           = CMD_LOAD;
    it.entry_index   = idx;
    it.start_time_ms = ms;
    it.query_time_us = rand41();
    pending_requests.push_back(it);
    plan_start_ms[idx] = ms;
    n_queued++;
  endfunction

  function automatic void queue_lookup(logic [TIME_W-1:0] t);
    in_t it;
    it.cmd           = CMD_LOOKUP;
    it.entry_index   = FRAME_W'($urandom);
    it.start_time_ms = START_W'($urandom);
    it.query_time_us = t;
    pending_requests.push_back(it);
    n_queued++;
  endfunction

  // load entries 0..n-1 with non-decreasing start times
  function automatic void build_rising_table(int n, int gap_max);
    longint acc;
    acc = $urandom_range(0, gap_max);
    for (int i = 0; i < n; i++) begin
      if (acc > longint'(START_MAX)) acc = longint'(START_MAX);
      queue_load(FRAME_W'(i), acc[START_W-1:0]);
      acc += $urandom_range(0, gap_max);
    end
  endfunction

  // query time near interval edges, at the duration, or anywhere
  function automatic logic [TIME_W-1:0] pick_query_time();
    longint n, k, s, nxt, span, dur, t;
    n   = longint'(frame_count_cfg);
    dur = longint'(clip_dur_cfg);
    if (n > longint'(DEPTH)) n = longint'(DEPTH);
    if (n == 0) return rand41();
    k = $urandom_range(0, int'(n - 1));
    s = longint'(plan_start_ms[k]) * 1000;
    if (k < n - 1) nxt = longint'(plan_start_ms[k + 1]) * 1000;
    else nxt = dur + 1;
    span = nxt - s;
    case ($urandom_range(0, 9))
      0: t = s;
      1: t = s - 1;
      2: t = s + 1;
      3: t = nxt - 1;
      4: t = (span > 0) ? s + longint'(rand64() % 64'(span)) : s;
      5: t = dur;
      6: t = dur + 1;
      7: t = longint'(rand41());
      8: t = longint'(rand64() % 64'(dur + 1));
      default: t = s + $urandom_range(0, 2000);
    endcase
    return t[TIME_W-1:0];
  endfunction

  // register write through the configuration channel
  task automatic write_reg(reg_e r, logic [TIME_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (r)
      REG_FRAME_COUNT:   frame_count_cfg = v[COUNT_W-1:0];
      REG_CLIP_DURATION: clip_dur_cfg    = v;
      default: ;
    endcase
  endtask

  // both registers, with junk above the frame count field
  task automatic apply_setting(logic [COUNT_W-1:0] count, logic [TIME_W-1:0] dur);
    logic [TIME_W-1:0] junk;
    junk = rand41();
    write_reg(REG_FRAME_COUNT, {junk[TIME_W-1:COUNT_W], count});
    write_reg(REG_CLIP_DURATION, dur);
    n_settings++;
  endtask

  task automatic wait_drained();
    while (n_checked < n_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    int          n;
    int          kind;
    int          lookups;
    int          phase_no;
    int unsigned random_items;
    bit          held;
    longint      last_us;
    logic [TIME_W-1:0] dur;

    phase_no     = 0;
    random_items = 0;
    held         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni        <= 1'b1;

    // single frame with the reset registers, only time zero is inside
    queue_load('0, '0);
    queue_lookup('0);
    queue_lookup(TIME_W'(1));
    queue_lookup(TIME_MAX);
    wait_drained();

    // zero frame count rejects every time
    apply_setting('0, TIME_MAX);
    queue_lookup('0);
    queue_lookup(TIME_W'(12345));
    wait_drained();

    // four frames, two with the same start, last at the top start time
    apply_setting(COUNT_W'(4), TIME_MAX);
    queue_load(FRAME_W'(0), START_W'(5));
    queue_load(FRAME_W'(1), START_W'(5));
    queue_load(FRAME_W'(2), START_W'(10));
    queue_load(FRAME_W'(3), START_MAX);
    queue_lookup(TIME_W'(4999));
    queue_lookup(TIME_W'(5000));
    queue_lookup(TIME_W'(9999));
    queue_lookup(TIME_W'(10000));
    queue_lookup(TIME_W'(longint'(START_MAX) * 1000 - 1));
    queue_lookup(TIME_W'(longint'(START_MAX) * 1000));
    queue_lookup(TIME_MAX);
    wait_drained();

    // duration below later starts, then an out of order start time
    apply_setting(COUNT_W'(4), TIME_W'(7000));
    queue_lookup(TIME_W'(8000));
    queue_lookup(TIME_W'(12000));
    queue_load(FRAME_W'(2), START_W'(1));
    queue_lookup(TIME_W'(6000));
    queue_lookup(TIME_W'(3000));
    wait_drained();

    // fill the whole table with rising start times
    build_rising_table(DEPTH, 1 << 21);
    queue_load(FRAME_W'(DEPTH - 1), START_MAX);

    // random phases, each with its own setting
    while (random_items < RANDOM_ITEMS) begin
      wait_drained();

      // frame count and an optional reload of the table prefix
      kind = $urandom_range(0, 15);
      if (phase_no == 0) n = DEPTH;
      else if (phase_no == 1) n = (1 << COUNT_W) - 1;
      else if (kind == 0) n = 0;
      else if (kind == 1) n = $urandom_range(DEPTH + 1, (1 << COUNT_W) - 1);
      else if (kind == 2) n = DEPTH;
      else if (kind == 3) n = $urandom_range(1, DEPTH);
      else n = (kind < 7) ? $urandom_range(1, 4) : $urandom_range(1, 32);

      // clip duration around the end of the last frame
      last_us = (n == 0) ? 0 : longint'(plan_start_ms[(n > DEPTH) ? DEPTH - 1 : n - 1]) * 1000;
      if (kind >= 4) begin
        case ($urandom_range(0, 3))
          0:       last_us = 0;
          1:       last_us = 1000 * longint'($urandom_range(0, 50));
          2:       last_us = 1000 * longint'($urandom_range(0, 1 << 20));
          default: last_us = 1000 * longint'($urandom_range(0, 1 << 30));
        endcase
        last_us += 1000 * longint'(n) * 3;
      end
      case ($urandom_range(0, 7))
        0:       dur = TIME_MAX;
        1:       dur = TIME_W'(last_us / 2);
        default: dur = TIME_W'(last_us + $urandom_range(0, 4000));
      endcase
      apply_setting(COUNT_W'(n), dur);

      if (kind >= 4 && phase_no > 1) begin
        if ($urandom_range(0, 7) == 0) begin
          for (int i = 0; i < n; i++) queue_load(FRAME_W'(i), START_W'($urandom));
        end else begin
          case ($urandom_range(0, 3))
            0:       build_rising_table(n, 3);
            1:       build_rising_table(n, 1000);
            2:       build_rising_table(n, 1 << 16);
            default: build_rising_table(n, 1 << 21);
          endcase
          // keep the duration past the last start in most phases
          last_us = longint'(plan_start_ms[n - 1]) * 1000;
          if (longint'(clip_dur_cfg) < last_us && $urandom_range(0, 3) != 0) begin
            wait_drained();
            write_reg(REG_CLIP_DURATION, TIME_W'(last_us + $urandom_range(0, 4000)));
          end
        end
        random_items += n;
      end

      // long receiver hold-off while the sender keeps offering
      if (send_idle_pct == 0 && !held) begin
        held = 1'b1;
        hold_kicks <= hold_kicks + 1;
      end

      lookups = $urandom_range(8, 20);
      for (int i = 0; i < lookups; i++) begin
        if ($urandom_range(0, 9) == 0) queue_load(FRAME_W'($urandom), START_W'($urandom));
        else queue_lookup(pick_query_time());
      end
      random_items += lookups;
      phase_no++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (frame_answers_q.size() != 0) begin
      n_errors++;
      $display("%0d predicted results never returned", frame_answers_q.size());
    end
    $display("ran %0d loads and %0d lookups (%0d outside every frame) over %0d settings",
             n_loads, n_lookups, n_misses, n_settings);
    $display("with both sides idling in turn and one %0d cycle output hold-off", HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
